// ----- hw/rtl/rogk_pkg.sv -----
package rogk_pkg;

  localparam int HEIGHT_W     = 16;
  localparam int NOISE_W      = 26;
  localparam int EST_W        = 32;
  localparam int FRAC_W       = 24;
  localparam int GAIN_W       = FRAC_W + 1;
  localparam int CFG_DATA_W   = 26;
  localparam int CFG_INDEX_W  = 2;

  localparam int DEFAULT_WINDOW_DEPTH = 10;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_ESTIMATE   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_COVARIANCE = 2'd3;

  localparam logic [NOISE_W-1:0]  RST_PROCESS_NOISE      = 26'd36909;
  localparam logic [NOISE_W-1:0]  RST_MEASUREMENT_NOISE  = 26'd671089;
  localparam logic [HEIGHT_W-1:0] RST_INITIAL_ESTIMATE   = 16'd3;
  localparam logic [NOISE_W-1:0]  RST_INITIAL_COVARIANCE = 26'd16777216;

  localparam logic [GAIN_W-1:0]   ONE_Q24 = GAIN_W'(1) << FRAC_W;

endpackage

// ----- hw/rtl/rogk_in_if.sv -----
interface rogk_in_if import rogk_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] raw_height;

  modport source (output valid, output raw_height, input ready);
  modport sink   (input valid, input raw_height, output ready);
endinterface

// ----- hw/rtl/rogk_out_if.sv -----
interface rogk_out_if import rogk_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [HEIGHT_W-1:0] filtered_height;
  logic signed [HEIGHT_W-1:0] vertical_velocity;
  logic        [HEIGHT_W-1:0] window_average;
  logic                       sample_rejected;

  modport source (output valid, output filtered_height, output vertical_velocity,
                  output window_average, output sample_rejected, input ready);
  modport sink   (input valid, input filtered_height, input vertical_velocity,
                  input window_average, input sample_rejected, output ready);
endinterface

// ----- hw/rtl/range_outlier_gate_kalman_core.sv -----
// Channel   Dir  Payload                                              Transfer
// samples   in   raw_height[15:0]                                     valid & ready
// results   out  filtered_height, vertical_velocity (signed),         valid & ready
//                window_average, sample_rejected
// cfg       in   cfg_index[1:0], cfg_data[25:0]                        cfg_write
//
// After the transfer, one pass through the shared multiplier gives the window
// average (by the reciprocal of the depth), the one-bit-a-cycle divider gives
// the Kalman gain, then two more passes through the multiplier, and the result
// is registered in the final step.
// rst (synchronous) clears the ring, sum, pointer and last output and reloads the
// registers, estimate and covariance from their reset values.
// A result waits in the output register; the block holds in its last step until
// the register is free, and samples is not ready until the step finishes.
module range_outlier_gate_kalman_core import rogk_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  rogk_in_if.sink                samples,
  rogk_out_if.source             results,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int SUM_W  = HEIGHT_W + $clog2(WINDOW_DEPTH);
  localparam int DQW    = GAIN_W;
  localparam int REM_W  = NOISE_W + 1;
  localparam int CNT_W  = $clog2(DQW + 1);
  localparam int PROD_W = GAIN_W + EST_W;

  // exact floor(sum / depth) for any sum below 2^SUM_W
  localparam int AVG_SH = SUM_W + $clog2(WINDOW_DEPTH);
  localparam logic [GAIN_W-1:0] AVG_RECIP =
    GAIN_W'(((64'd1 << AVG_SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AVG  = 3'd1;
  localparam logic [2:0] S_GATE = 3'd2;
  localparam logic [2:0] S_GAIN = 3'd3;
  localparam logic [2:0] S_KG   = 3'd4;
  localparam logic [2:0] S_MUL1 = 3'd5;
  localparam logic [2:0] S_MUL2 = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]          state;

  logic [NOISE_W-1:0]  process_noise;
  logic [NOISE_W-1:0]  measurement_noise;
  logic [HEIGHT_W-1:0] initial_estimate;
  logic [NOISE_W-1:0]  initial_covariance;

  logic [HEIGHT_W-1:0] sample_ring [WINDOW_DEPTH];
  logic [PTR_W-1:0]    ring_pointer;
  logic [SUM_W-1:0]    ring_sum;
  logic [EST_W-1:0]    height_estimate;
  logic [NOISE_W-1:0]  error_covariance;
  logic [HEIGHT_W-1:0] previous_output;

  // datapath registers
  logic [HEIGHT_W-1:0] raw;
  logic [HEIGHT_W-1:0] avg;
  logic                rejected;
  logic [HEIGHT_W-1:0] meas;
  logic [NOISE_W-1:0]  pt;
  logic [REM_W-1:0]    den;
  logic [GAIN_W-1:0]   kg;
  logic                up;
  logic [EST_W-1:0]    diff;
  logic [PROD_W-1:0]   prod;

  // divider for the Kalman gain
  logic [REM_W-1:0]    rem;
  logic [DQW-1:0]      dq;
  logic [REM_W-1:0]    div_den;
  logic [CNT_W-1:0]    cnt;

  logic [REM_W:0]      shifted;
  logic                ge;
  logic [REM_W-1:0]    rem_next;

  always_comb begin
    shifted  = {rem, dq[DQW-1]};
    ge       = shifted >= {1'b0, div_den};
    rem_next = ge ? REM_W'(shifted - {1'b0, div_den}) : shifted[REM_W-1:0];
  end

  // ring update at the input transfer
  logic [SUM_W-1:0] sum_next;

  always_comb begin
    sum_next = ring_sum - SUM_W'(sample_ring[ring_pointer]) + SUM_W'(samples.raw_height);
  end

  // gate
  logic [HEIGHT_W-1:0] quot_avg;
  logic [HEIGHT_W-1:0] half;
  logic [HEIGHT_W:0]   three_half;
  logic                rej_now;
  logic [NOISE_W:0]    pt_sum;
  logic [NOISE_W-1:0]  pt_now;
  logic [REM_W-1:0]    den_now;

  always_comb begin
    quot_avg   = prod[AVG_SH +: HEIGHT_W];
    half       = quot_avg >> 1;
    three_half = {half, 1'b0} + {1'b0, half};
    rej_now    = (raw < half) || ({1'b0, raw} > three_half);
    pt_sum     = {1'b0, error_covariance} + {1'b0, process_noise};
    pt_now     = pt_sum[NOISE_W] ? {NOISE_W{1'b1}} : pt_sum[NOISE_W-1:0];
    den_now    = {1'b0, pt_now} + {1'b0, measurement_noise};
  end

  // gain clamp and innovation
  logic [GAIN_W-1:0] quot_gain;
  logic [EST_W-1:0]  target;

  always_comb begin
    quot_gain = dq[GAIN_W-1:0];
    target    = {meas, {(EST_W-HEIGHT_W){1'b0}}};
  end

  // shared multiplier operands
  logic [GAIN_W-1:0] mul_a;
  logic [EST_W-1:0]  mul_b;

  always_comb begin
    if (state == S_MUL1) begin
      mul_a = kg;
      mul_b = diff;
    end else if (state == S_AVG) begin
      mul_a = AVG_RECIP;
      mul_b = EST_W'(ring_sum);
    end else begin
      mul_a = ONE_Q24 - kg;
      mul_b = EST_W'(pt);
    end
  end

  logic [EST_W-1:0] mag;
  assign mag = prod[FRAC_W +: EST_W];

  // output formatting
  logic [HEIGHT_W-1:0]        filt;
  logic signed [HEIGHT_W:0]   delta;
  logic signed [HEIGHT_W+4:0] vel_wide;
  logic signed [HEIGHT_W-1:0] vel;

  always_comb begin
    filt     = height_estimate[EST_W-1 -: HEIGHT_W];
    delta    = $signed({1'b0, filt}) - $signed({1'b0, previous_output});
    vel_wide = ((HEIGHT_W+5)'(delta) <<< 3) + ((HEIGHT_W+5)'(delta) <<< 1);
    if (vel_wide > (HEIGHT_W+5)'(32767)) begin
      vel = 16'sh7fff;
    end else if (vel_wide < -(HEIGHT_W+5)'(32768)) begin
      vel = 16'sh8000;
    end else begin
      vel = vel_wide[HEIGHT_W-1:0];
    end
  end

  logic out_free;
  assign out_free      = !results.valid || results.ready;
  assign samples.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      process_noise      <= RST_PROCESS_NOISE;
      measurement_noise  <= RST_MEASUREMENT_NOISE;
      initial_estimate   <= RST_INITIAL_ESTIMATE;
      initial_covariance <= RST_INITIAL_COVARIANCE;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        sample_ring[i] <= '0;
      end
      ring_pointer       <= '0;
      ring_sum           <= '0;
      height_estimate    <= {RST_INITIAL_ESTIMATE, {(EST_W-HEIGHT_W){1'b0}}};
      error_covariance   <= RST_INITIAL_COVARIANCE;
      previous_output    <= '0;
      results.valid      <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end

      if (cfg_write) begin
        unique case (cfg_index)
          REG_PROCESS_NOISE:     process_noise     <= cfg_data[NOISE_W-1:0];
          REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data[NOISE_W-1:0];
          REG_INITIAL_ESTIMATE: begin
            initial_estimate <= cfg_data[HEIGHT_W-1:0];
            height_estimate  <= {cfg_data[HEIGHT_W-1:0], {(EST_W-HEIGHT_W){1'b0}}};
          end
          REG_INITIAL_COVARIANCE: begin
            initial_covariance <= cfg_data[NOISE_W-1:0];
            error_covariance   <= cfg_data[NOISE_W-1:0];
          end
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            sample_ring[ring_pointer] <= samples.raw_height;
            ring_sum <= sum_next;
            ring_pointer <= (ring_pointer == PTR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                      : ring_pointer + 1'b1;
            raw     <= samples.raw_height;
            state   <= S_AVG;
          end
        end
        S_AVG: begin
          prod  <= mul_a * mul_b;
          state <= S_GATE;
        end
        S_GAIN: begin
          rem <= rem_next;
          dq  <= {dq[DQW-2:0], ge};
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= S_KG;
          end
        end
        S_GATE: begin
          avg      <= quot_avg;
          rejected <= rej_now;
          meas     <= rej_now ? previous_output : raw;
          pt       <= pt_now;
          den      <= den_now;
          // dividend pt * 2^24: quotient fits GAIN_W bits, so start with pt >> 1
          rem      <= REM_W'(pt_now >> 1);
          dq       <= {pt_now[0], {(DQW-1){1'b0}}};
          div_den  <= den_now;
          cnt      <= CNT_W'(GAIN_W);
          state    <= S_GAIN;
        end
        S_KG: begin
          if (den == '0) begin
            kg <= '0;
          end else begin
            kg <= (quot_gain > ONE_Q24) ? ONE_Q24 : quot_gain;
          end
          up    <= target >= height_estimate;
          diff  <= (target >= height_estimate) ? target - height_estimate
                                               : height_estimate - target;
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod  <= mul_a * mul_b;
          state <= S_MUL2;
        end
        S_MUL2: begin
          height_estimate <= up ? height_estimate + mag : height_estimate - mag;
          prod            <= mul_a * mul_b;
          state           <= S_FIN;
        end
        S_FIN: begin
          error_covariance <= prod[FRAC_W +: NOISE_W];
          if (out_free) begin
            results.valid             <= 1'b1;
            results.filtered_height   <= filt;
            results.vertical_velocity <= vel;
            results.window_average    <= avg;
            results.sample_rejected   <= rejected;
            previous_output           <= filt;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // initial registers are held only for their loads on write
  logic unused_init;
  assign unused_init = ^{initial_estimate, initial_covariance};

endmodule
